[rtl/rvx_pkg.sv]
// Shared types, opcodes and status codes for the RV64I execute block.
package rvx_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;

    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] ALT_FUNCT7 = 7'h20;
    localparam logic [5:0] SRA_KIND   = 6'h10;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MISALIGNED  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL     = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Instruction class decided in the front part.
    typedef enum logic [2:0] {
        K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_IMM, K_OP, K_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] status;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        logic [63:0] imm;
    } t_dec;

endpackage

[rtl/rvx_decode.sv]
// Front part: classifies an instruction word and extracts its immediate.
module rvx_decode
    import rvx_pkg::*;
(
    input  logic [31:0] i_instruction,
    output t_dec        o_dec
);

    logic [6:0] opc;
    logic       use_rs1;
    logic       use_rs2;
    logic       use_rd;

    assign opc = i_instruction[6:0];

    always_comb begin
        o_dec.f3  = i_instruction[14:12];
        o_dec.f7  = i_instruction[31:25];
        o_dec.rd  = i_instruction[11:7];
        o_dec.rs1 = i_instruction[19:15];
        o_dec.rs2 = i_instruction[24:20];
        o_dec.status = ST_OK;
        o_dec.imm = {{52{i_instruction[31]}}, i_instruction[31:20]};
        use_rs1 = 1'b1;
        use_rs2 = 1'b0;
        use_rd  = 1'b1;
        unique case (opc)
            OPC_LUI: begin
                o_dec.kind = K_LUI; use_rs1 = 1'b0;
                o_dec.imm = {{32{i_instruction[31]}}, i_instruction[31:12], 12'd0};
            end
            OPC_AUIPC: begin
                o_dec.kind = K_AUIPC; use_rs1 = 1'b0;
                o_dec.imm = {{32{i_instruction[31]}}, i_instruction[31:12], 12'd0};
            end
            OPC_JAL: begin
                o_dec.kind = K_JAL; use_rs1 = 1'b0;
                o_dec.imm = {{44{i_instruction[31]}}, i_instruction[19:12],
                             i_instruction[20], i_instruction[30:21], 1'b0};
            end
            OPC_JALR: o_dec.kind = K_JALR;
            OPC_BRANCH: begin
                o_dec.kind = K_BRANCH; use_rd = 1'b0; use_rs2 = 1'b1;
                o_dec.imm = {{52{i_instruction[31]}}, i_instruction[7],
                             i_instruction[30:25], i_instruction[11:8], 1'b0};
            end
            OPC_IMM: o_dec.kind = K_IMM;
            OPC_OP: begin
                o_dec.kind = K_OP; use_rs2 = 1'b1;
            end
            default: begin
                o_dec.kind = K_BAD; o_dec.status = ST_UNSUPPORTED;
            end
        endcase
        if (o_dec.status == ST_OK &&
            ((use_rd && 32'(o_dec.rd) >= 32'(REG_COUNT)) ||
             (use_rs1 && 32'(o_dec.rs1) >= 32'(REG_COUNT)) ||
             (use_rs2 && 32'(o_dec.rs2) >= 32'(REG_COUNT)))) begin
            o_dec.status = ST_ILLEGAL;
        end
    end

endmodule

[rtl/rvx_queue.sv]
// Two-entry queue between the decode front and the execute back.
module rvx_queue
    import rvx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_dec o_data
);

    t_dec       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

[rtl/rvx_execute.sv]
// Back part: register file, program counter, ALU, branch unit and output register.
module rvx_execute
    import rvx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_dec        i_dec,
    output logic        o_pop,
    input  logic        i_pc_load,
    input  logic [63:0] i_pc_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_dest_reg,
    output logic [63:0] o_write_value,
    output logic        o_branch_taken,
    output logic [1:0]  o_status
);

    logic [63:0] r_regs [REG_COUNT];
    logic [63:0] r_pc;
    logic        r_valid;
    logic [63:0] r_next_pc;
    logic        r_wr;
    logic [4:0]  r_rd;
    logic [63:0] r_val;
    logic        r_taken;
    logic [1:0]  r_status;

    logic [63:0] a, b, imm, val, next, target, pc4, op2;
    logic        wr, taken, cond, lts, ltu;
    logic [1:0]  status;
    logic [5:0]  sh;
    logic        fire;

    assign o_pop = i_valid && (!r_valid || i_ready);
    assign fire = o_pop;

    always_comb begin
        a = (i_dec.rs1 == 5'd0) ? 64'd0 : r_regs[i_dec.rs1[REG_IDX_W-1:0]];
        b = (i_dec.rs2 == 5'd0) ? 64'd0 : r_regs[i_dec.rs2[REG_IDX_W-1:0]];
        imm = i_dec.imm;
        pc4 = r_pc + 64'd4;
        // Branches and register-register operations compare against rs2.
        op2 = (i_dec.kind == K_OP || i_dec.kind == K_BRANCH) ? b : imm;
        lts = $signed(a) < $signed(op2);
        ltu = a < op2;
        sh = op2[5:0];
        status = i_dec.status;
        val = 64'd0;
        wr = 1'b0;
        taken = 1'b0;
        next = pc4;
        target = 64'd0;
        cond = 1'b0;
        if (status == ST_OK) begin
            case (i_dec.kind)
                K_LUI: begin val = imm; wr = 1'b1; end
                K_AUIPC: begin val = r_pc + imm; wr = 1'b1; end
                K_JAL, K_JALR: begin
                    target = (i_dec.kind == K_JAL) ? r_pc + imm
                                                   : ((a + imm) & ~64'd1);
                    if (target[1:0] != 2'd0) status = ST_MISALIGNED;
                    else begin
                        val = pc4; wr = 1'b1; next = target; taken = 1'b1;
                    end
                end
                K_BRANCH: begin
                    case (i_dec.f3)
                        F3_BEQ:  cond = (a == b);
                        F3_BNE:  cond = (a != b);
                        F3_BLT:  cond = lts;
                        F3_BGE:  cond = !lts;
                        F3_BLTU: cond = ltu;
                        F3_BGEU: cond = !ltu;
                        default: status = ST_ILLEGAL;
                    endcase
                    target = r_pc + imm;
                    if (status == ST_OK && cond) begin
                        if (target[1:0] != 2'd0) status = ST_MISALIGNED;
                        else begin next = target; taken = 1'b1; end
                    end
                end
                K_IMM, K_OP: begin
                    wr = 1'b1;
                    if (i_dec.kind == K_OP && i_dec.f7 == ALT_FUNCT7
                        && i_dec.f3 == F3_ADD) begin
                        val = a - b;
                    end else if (i_dec.kind == K_OP && i_dec.f7 == ALT_FUNCT7
                                 && i_dec.f3 == F3_SR) begin
                        val = 64'($signed(a) >>> sh);
                    end else if (i_dec.kind == K_OP && i_dec.f7 != 7'd0) begin
                        status = ST_ILLEGAL;
                    end else begin
                        case (i_dec.f3)
                            F3_ADD:  val = a + op2;
                            F3_SLT:  val = {63'd0, lts};
                            F3_SLTU: val = {63'd0, ltu};
                            F3_XOR:  val = a ^ op2;
                            F3_OR:   val = a | op2;
                            F3_AND:  val = a & op2;
                            F3_SLL: begin
                                if (i_dec.kind == K_IMM && imm[11:6] != 6'd0)
                                    status = ST_ILLEGAL;
                                else val = a << sh;
                            end
                            default: begin
                                if (i_dec.kind == K_OP || imm[11:6] == 6'd0)
                                    val = a >> sh;
                                else if (imm[11:6] == SRA_KIND)
                                    val = 64'($signed(a) >>> sh);
                                else status = ST_ILLEGAL;
                            end
                        endcase
                    end
                end
                default: status = ST_UNSUPPORTED;
            endcase
        end
        if (status != ST_OK) begin
            wr = 1'b0; taken = 1'b0; next = pc4;
        end
        if (i_dec.rd == 5'd0) wr = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 64'd0;
            r_valid <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) r_regs[k] <= 64'd0;
        end else begin
            if (i_pc_load) r_pc <= i_pc_value;
            else if (fire) r_pc <= next;
            if (fire && wr) r_regs[i_dec.rd[REG_IDX_W-1:0]] <= val;
            if (fire) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_next_pc <= next;
            r_wr <= wr;
            r_rd <= wr ? i_dec.rd : 5'd0;
            r_val <= wr ? val : 64'd0;
            r_taken <= taken;
            r_status <= status;
        end
    end

    assign o_valid = r_valid;
    assign o_next_pc = r_next_pc;
    assign o_reg_written = r_wr;
    assign o_dest_reg = r_rd;
    assign o_write_value = r_val;
    assign o_branch_taken = r_taken;
    assign o_status = r_status;

endmodule

[rtl/rv64i_integer_execute.sv]
// Top level of the RV64I integer execute block.
// Path: an accepted instruction waits in the decode queue; its result is then
// held in the output register. Throughput: one instruction per cycle while the
// output is not stalled, set by the PC and register file loop.
// Reset: registers, PC and start address clear to zero; writing the start
// address also loads the PC.
module rv64i_integer_execute
    import rvx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // instruction
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[63:0], reg_written[64], dest_reg[69:65], write_value[133:70],
    // branch_taken[134], status[136:135], zero fill[143:137]
    output logic [143:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    t_dec        dec, q_dec;
    logic        q_full, q_valid, pop;
    logic [63:0] r_start;
    logic        cfg_wr;
    logic        reg_written, branch_taken;
    logic [4:0]  dest_reg;
    logic [63:0] next_pc, write_value;
    logic [1:0]  status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 4'd0);
    assign prdata = (paddr == 4'd0) ? r_start : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start <= 64'd0;
        else if (cfg_wr) r_start <= pwdata;
    end

    rvx_decode u_decode (
        .i_instruction (s_axis_tdata),
        .o_dec         (dec)
    );

    assign s_axis_tready = !q_full;

    rvx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && !q_full),
        .i_data  (dec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_dec)
    );

    rvx_execute u_execute (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_dec          (q_dec),
        .o_pop          (pop),
        .i_pc_load      (cfg_wr),
        .i_pc_value     (pwdata),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_next_pc      (next_pc),
        .o_reg_written  (reg_written),
        .o_dest_reg     (dest_reg),
        .o_write_value  (write_value),
        .o_branch_taken (branch_taken),
        .o_status       (status)
    );

    assign m_axis_tdata = {7'd0, status, branch_taken, write_value, dest_reg,
                           reg_written, next_pc};

endmodule

[dv/rv64i_integer_execute_tb.sv]
// Self-checking testbench for the RV64I integer execute block.
module rv64i_integer_execute_tb
    import rvx_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic        branch_taken;
        logic [63:0] write_value;
        logic [4:0]  dest_reg;
        logic        reg_written;
        logic [63:0] next_pc;
    } t_retire;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    localparam logic [3:0] ADDR_START = 4'd0;

    rv64i_integer_execute dut (.*);

    always #4 i_clk = ~i_clk;

    logic [31:0] instr_queue[$];
    t_retire     retire_queue[$];
    logic [63:0] gpr[REG_COUNT];
    logic [63:0] pc_model;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;

    function automatic logic lt_s(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Executes one instruction on the shadow state and returns its retire record.
    function automatic t_retire execute_instr(logic [31:0] w);
        t_retire r;
        logic [6:0] opc;
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [63:0] a, b, ii, ij, ib, iu, tgt, val;
        logic [1:0] st;
        logic wr, tk, cond;
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12];
        rs1 = w[19:15]; rs2 = w[24:20]; f7 = w[31:25];
        a = (rs1 == 5'd0) ? '0 : gpr[rs1];
        b = (rs2 == 5'd0) ? '0 : gpr[rs2];
        ii = {{52{w[31]}}, w[31:20]};
        ib = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        ij = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        iu = {{32{w[31]}}, w[31:12], 12'h000};
        st = ST_OK; wr = 1'b0; tk = 1'b0; val = '0; tgt = '0; cond = 1'b0;
        case (opc)
            OPC_LUI: begin val = iu; wr = 1'b1; end
            OPC_AUIPC: begin val = pc_model + iu; wr = 1'b1; end
            OPC_JAL, OPC_JALR: begin
                tgt = (opc == OPC_JAL) ? pc_model + ij : ((a + ii) & ~64'd1);
                if (tgt[1:0] != 2'd0) st = ST_MISALIGNED;
                else begin val = pc_model + 64'd4; wr = 1'b1; tk = 1'b1; end
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  cond = a == b;
                    F3_BNE:  cond = a != b;
                    F3_BLT:  cond = lt_s(a, b);
                    F3_BGE:  cond = !lt_s(a, b);
                    F3_BLTU: cond = a < b;
                    F3_BGEU: cond = a >= b;
                    default: st = ST_ILLEGAL;
                endcase
                if (st == ST_OK && cond) begin
                    tgt = pc_model + ib;
                    if (tgt[1:0] != 2'd0) st = ST_MISALIGNED;
                    else tk = 1'b1;
                end
            end
            OPC_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  val = a + ii;
                    F3_SLT:  val = {63'd0, lt_s(a, ii)};
                    F3_SLTU: val = {63'd0, a < ii};
                    F3_XOR:  val = a ^ ii;
                    F3_OR:   val = a | ii;
                    F3_AND:  val = a & ii;
                    F3_SLL: begin
                        if (ii[11:6] == 6'd0) val = a << ii[5:0];
                        else st = ST_ILLEGAL;
                    end
                    default: begin
                        if (ii[11:6] == 6'd0) val = a >> ii[5:0];
                        else if (ii[11:6] == SRA_KIND) val = 64'($signed(a) >>> ii[5:0]);
                        else st = ST_ILLEGAL;
                    end
                endcase
            end
            OPC_OP: begin
                wr = 1'b1;
                if (f7 == ALT_FUNCT7 && f3 == F3_ADD) val = a - b;
                else if (f7 == ALT_FUNCT7 && f3 == F3_SR) val = 64'($signed(a) >>> b[5:0]);
                else if (f7 != 7'd0) st = ST_ILLEGAL;
                else case (f3)
                    F3_ADD:  val = a + b;
                    F3_SLL:  val = a << b[5:0];
                    F3_SLT:  val = {63'd0, lt_s(a, b)};
                    F3_SLTU: val = {63'd0, a < b};
                    F3_XOR:  val = a ^ b;
                    F3_SR:   val = a >> b[5:0];
                    F3_OR:   val = a | b;
                    default: val = a & b;
                endcase
            end
            default: st = ST_UNSUPPORTED;
        endcase
        if (st != ST_OK) begin wr = 1'b0; tk = 1'b0; end
        if (rd == 5'd0 || opc == OPC_BRANCH) wr = 1'b0;
        r.next_pc = tk ? tgt : pc_model + 64'd4;
        if (wr) gpr[rd] = val;
        pc_model = r.next_pc;
        r.reg_written = wr;
        r.dest_reg = wr ? rd : 5'd0;
        r.write_value = wr ? val : 64'd0;
        r.branch_taken = tk;
        r.status = st;
        return r;
    endfunction

    // Driver: sender side and result-side ready.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= instr_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Prediction on each accepted transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            retire_queue.push_back(execute_instr(s_axis_tdata));
        end
    end

    // Monitor: result side.
    always @(posedge i_clk) begin
        t_retire got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[136:0];
            if (retire_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = retire_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pc %h/%h wr %b/%b rd %0d/%0d ",
                            want.next_pc, got.next_pc, want.reg_written, got.reg_written,
                            want.dest_reg, got.dest_reg,
                            "val %h/%h tk %b/%b st %0d/%0d",
                            want.write_value, got.write_value,
                            want.branch_taken, got.branch_taken, want.status, got.status);
                end
            end
        end
    end

    task automatic apb_write(input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_START; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pc_model = value;
    endtask

    task automatic drain();
        while (instr_queue.size() > 0 || s_axis_tvalid || retire_queue.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly legal instructions with random operands, plus some raw noise.
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int k;
        w = $urandom;
        k = $urandom_range(99);
        if (k < 5) return w;
        else if (k < 20) w[6:0] = OPC_IMM;
        else if (k < 40) begin
            w[6:0] = OPC_IMM;
            w[14:12] = $urandom_range(1) ? F3_SLL : F3_SR;
            w[31:26] = $urandom_range(3) == 0 ? 6'($urandom)
                                              : ($urandom_range(1) ? SRA_KIND : 6'd0);
        end else if (k < 60) begin
            w[6:0] = OPC_OP;
            w[31:25] = $urandom_range(7) == 0 ? 7'($urandom)
                                              : ($urandom_range(1) ? ALT_FUNCT7 : 7'd0);
        end else if (k < 66) w[6:0] = OPC_LUI;
        else if (k < 72) w[6:0] = OPC_AUIPC;
        else if (k < 80) begin w[6:0] = OPC_JAL; w[21] = 1'b0; end
        else if (k < 86) w[6:0] = OPC_JALR;
        else begin w[6:0] = OPC_BRANCH; if ($urandom_range(3) != 0) w[8] = 1'b0; end
        // Occasionally force a small register set so branches more often compare equal values.
        if ($urandom_range(3) == 0) begin
            w[19:15] = 5'($urandom_range(3));
            w[24:20] = 5'($urandom_range(3));
        end
        return w;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (gpr[i]) gpr[i] = '0;
        pc_model = '0;
        @(posedge i_clk);

        // Directed: extremes, every register-register operation and the special cases.
        instr_queue.push_back({20'hfffff, 5'd1, OPC_LUI});
        instr_queue.push_back({20'h7ffff, 5'd2, OPC_LUI});
        instr_queue.push_back({12'h7ff, 5'd1, F3_ADD, 5'd3, OPC_IMM});
        instr_queue.push_back({12'h800, 5'd2, F3_ADD, 5'd0, OPC_IMM});
        instr_queue.push_back({12'hfff, 5'd1, F3_SLTU, 5'd4, OPC_IMM});
        instr_queue.push_back({12'h800, 5'd1, F3_SLT, 5'd5, OPC_IMM});
        instr_queue.push_back({6'd0, 6'd63, 5'd1, F3_SLL, 5'd6, OPC_IMM});
        instr_queue.push_back({SRA_KIND, 6'd63, 5'd1, F3_SR, 5'd7, OPC_IMM});
        instr_queue.push_back({6'h01, 6'd3, 5'd1, F3_SR, 5'd7, OPC_IMM});
        instr_queue.push_back({6'h10, 6'd3, 5'd1, F3_SLL, 5'd7, OPC_IMM});
        for (int f = 0; f < 8; f++)
            instr_queue.push_back({7'd0, 5'd2, 5'd1, 3'(f), 5'd8 + 5'(f), OPC_OP});
        instr_queue.push_back({ALT_FUNCT7, 5'd2, 5'd1, F3_ADD, 5'd16, OPC_OP});
        instr_queue.push_back({ALT_FUNCT7, 5'd3, 5'd1, F3_SR, 5'd17, OPC_OP});
        instr_queue.push_back({7'h01, 5'd2, 5'd1, F3_ADD, 5'd18, OPC_OP});
        instr_queue.push_back({20'h00100, 5'd1, OPC_AUIPC});
        instr_queue.push_back({1'b0, 10'd2, 1'b0, 8'd0, 5'd1, OPC_JAL});  // +4
        instr_queue.push_back({1'b0, 10'd1, 1'b0, 8'd0, 5'd1, OPC_JAL});  // misaligned
        instr_queue.push_back({12'd0, 5'd0, 3'd0, 5'd31, OPC_JALR});
        instr_queue.push_back({12'd3, 5'd0, 3'd0, 5'd31, OPC_JALR});      // bit 0 cleared, bit 1 set
        instr_queue.push_back({1'b0, 6'd0, 5'd0, 5'd0, F3_BEQ, 4'd4, 1'b0, OPC_BRANCH});
        instr_queue.push_back({1'b0, 6'd0, 5'd0, 5'd0, F3_BEQ, 4'd1, 1'b0, OPC_BRANCH});
        instr_queue.push_back({1'b0, 6'd0, 5'd0, 5'd0, 3'd2, 4'd4, 1'b0, OPC_BRANCH});
        instr_queue.push_back(32'h0000_0073);
        instr_queue.push_back(32'hffff_ffff);
        drain();

        apb_write(64'hffff_ffff_ffff_fff0);
        send_idle_pct = 15; recv_idle_pct = 61;
        repeat (500) instr_queue.push_back(rand_instr());
        drain();   // sender holds off until everything has retired

        apb_write({$urandom, $urandom} & ~64'd3);
        send_idle_pct = 61; recv_idle_pct = 15;
        repeat (500) instr_queue.push_back(rand_instr());
        drain();

        apb_write(64'd0);
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (300) instr_queue.push_back(rand_instr());
        drain();
        apb_write({$urandom, $urandom});
        repeat (300) instr_queue.push_back(rand_instr());
        drain();

        if (mismatches == 0 && retire_queue.size() == 0)
            $display("rv64i_integer_execute test passed");
        else
            $display("rv64i_integer_execute test failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("rv64i_integer_execute test failed");
        $finish;
    end
endmodule
